>>> design/homogeneous_vertex_transform_core_defines.svh
// Assertion macros for the vertex transform core
`ifndef HOMOGENEOUS_VERTEX_TRANSFORM_CORE_DEFINES_SVH
`define HOMOGENEOUS_VERTEX_TRANSFORM_CORE_DEFINES_SVH

// a condition on one edge implies a consequence on the next edge
`define HVT_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

// a condition on one edge implies a consequence on the same edge
`define HVT_ASSERT_SAME(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

`endif

>>> design/hvt_pkg.sv
package hvt_pkg;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_VEC   = 2'd1;
    localparam logic [1:0] FUNC_POINT = 2'd2;

    localparam logic signed [31:0] Q_ONE   = 32'sh0001_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = -32'sh8000_0000;

    typedef struct packed {
        logic          load_vec;   // capture the input word
        logic          mat_wr;     // write one matrix element
        logic          mac;        // accumulate one product
        logic [1:0]    row;
        logic [1:0]    col;
        logic          acc_clr;
        logic          row_store;  // saturate accumulator into result row
        logic          div_start;  // start reciprocal
        logic          scale;      // multiply one numerator by reciprocal
        logic [1:0]    scale_idx;
        logic          scale_store;
        logic          out_fire;
    } t_cmd;

    typedef struct packed {
        logic          div_done;
        logic          den_zero;
    } t_status;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v,
                                                 output logic f);
        f = 1'b0;
        if (v > 66'(S32_MAX)) begin
            f = 1'b1;
            return S32_MAX;
        end else if (v < 66'(S32_MIN)) begin
            f = 1'b1;
            return S32_MIN;
        end
        return v[31:0];
    endfunction

endpackage

>>> design/homogeneous_vertex_transform_core.sv
// Matrix-vector transform core. Raise start while busy is low to issue a word;
// a matrix write is taken while idle, leaves busy low and gives no result. A
// transform runs four serial four-term multiply-accumulates, one per output row;
// a point transform then runs the one-bit-a-cycle reciprocal divider and scales
// the three numerators, unless its denominator is zero. The next word can be
// taken while o_valid is high.
// The result is on the ports for one
// cycle with o_valid high; the receiver cannot stall it, so capture it then.
`include "homogeneous_vertex_transform_core_defines.svh"

module homogeneous_vertex_transform_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_func,
    input  logic [3:0]         i_elem_index,
    input  logic signed [31:0] i_elem_value,
    input  logic signed [31:0] i_in_x,
    input  logic signed [31:0] i_in_y,
    input  logic signed [31:0] i_in_z,
    input  logic signed [31:0] i_in_w,
    output logic               o_valid,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic signed [31:0] o_out_w,
    output logic               o_div_by_zero,
    output logic               o_saturated
);

    hvt_pkg::t_cmd    w_cmd;
    hvt_pkg::t_status w_status;
    logic             w_busy;

    hvt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start && !w_busy),
        .i_func  (i_func),
        .i_status(w_status),
        .o_cmd   (w_cmd),
        .o_busy  (w_busy)
    );

    hvt_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_func       (i_func),
        .i_elem_index (i_elem_index),
        .i_elem_value (i_elem_value),
        .i_in_x       (i_in_x),
        .i_in_y       (i_in_y),
        .i_in_z       (i_in_z),
        .i_in_w       (i_in_w),
        .o_status     (w_status),
        .o_valid      (o_valid),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_z      (o_out_z),
        .o_out_w      (o_out_w),
        .o_div_by_zero(o_div_by_zero),
        .o_saturated  (o_saturated)
    );

    assign busy = w_busy;

    `HVT_ASSERT_NEXT(a_write_no_busy, i_clk, i_rst_n, start && !busy && i_func == hvt_pkg::FUNC_WRITE, !busy, "write left core busy")
    `HVT_ASSERT_NEXT(a_xform_busy, i_clk, i_rst_n, start && !busy && i_func == hvt_pkg::FUNC_VEC, busy, "transform not started")
    `HVT_ASSERT_SAME(a_flags_excl, i_clk, i_rst_n, o_valid, !(o_div_by_zero && o_saturated), "divide by zero with saturation")

endmodule

>>> design/hvt_ctrl.sv
module hvt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [1:0]      i_func,
    input  hvt_pkg::t_status i_status,
    output hvt_pkg::t_cmd   o_cmd,
    output logic            o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_ROWST,
        S_DIV,
        S_SCALE,
        S_SCST,
        S_OUT
    } t_state;

    t_state      r_state;
    logic [1:0]  r_func;
    logic [1:0]  r_row;
    logic [1:0]  r_col;
    logic [1:0]  r_sidx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_func  <= hvt_pkg::FUNC_VEC;
            r_row   <= 2'd0;
            r_col   <= 2'd0;
            r_sidx  <= 2'd0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_row <= 2'd0;
                    r_col <= 2'd0;
                    r_sidx <= 2'd0;
                    r_func <= i_func;
                    if (i_start && (i_func == hvt_pkg::FUNC_VEC ||
                                    i_func == hvt_pkg::FUNC_POINT)) begin
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    r_col <= r_col + 2'd1;
                    if (r_col == 2'd3) begin
                        r_state <= S_ROWST;
                    end
                end
                S_ROWST: begin
                    r_row <= r_row + 2'd1;
                    if (r_row != 2'd3) begin
                        r_state <= S_MAC;
                    end else if (r_func == hvt_pkg::FUNC_POINT) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_DIV: begin
                    if (i_status.den_zero) begin
                        r_state <= S_OUT;
                    end else if (i_status.div_done) begin
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: r_state <= S_SCST;
                S_SCST: begin
                    r_sidx <= r_sidx + 2'd1;
                    r_state <= (r_sidx == 2'd2) ? S_OUT : S_SCALE;
                end
                S_OUT:   r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.row = r_row;
        o_cmd.col = r_col;
        o_cmd.scale_idx = r_sidx;
        case (r_state)
            S_IDLE: begin
                o_cmd.load_vec = i_start;
                o_cmd.mat_wr = i_start && (i_func == hvt_pkg::FUNC_WRITE);
                o_cmd.acc_clr = 1'b1;
            end
            S_MAC:   o_cmd.mac = 1'b1;
            S_ROWST: begin
                o_cmd.row_store = 1'b1;
                o_cmd.acc_clr = 1'b1;
                o_cmd.div_start = (r_row == 2'd3) && (r_func == hvt_pkg::FUNC_POINT);
            end
            S_SCALE: o_cmd.scale = 1'b1;
            S_SCST:  o_cmd.scale_store = 1'b1;
            S_OUT:   o_cmd.out_fire = 1'b1;
            default: o_cmd = o_cmd;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

>>> design/hvt_dp.sv
module hvt_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hvt_pkg::t_cmd       i_cmd,
    input  logic [1:0]          i_func,
    input  logic [3:0]          i_elem_index,
    input  logic signed [31:0]  i_elem_value,
    input  logic signed [31:0]  i_in_x,
    input  logic signed [31:0]  i_in_y,
    input  logic signed [31:0]  i_in_z,
    input  logic signed [31:0]  i_in_w,
    output hvt_pkg::t_status    o_status,
    output logic                o_valid,
    output logic signed [31:0]  o_out_x,
    output logic signed [31:0]  o_out_y,
    output logic signed [31:0]  o_out_z,
    output logic signed [31:0]  o_out_w,
    output logic                o_div_by_zero,
    output logic                o_saturated
);

    logic signed [31:0] r_mat [16];
    logic signed [31:0] r_vec [4];
    logic               r_point;
    logic signed [49:0] r_acc;
    logic signed [31:0] r_res [4];
    logic               r_sat;
    logic               r_sat_num;
    logic signed [63:0] r_prod;

    // reciprocal divider: 2^32 / mag, restoring, one bit a cycle
    logic               r_div_busy;
    logic               r_div_done;
    logic [5:0]         r_div_cnt;
    logic [32:0]        r_rem;
    logic [32:0]        r_quo;
    logic [31:0]        r_mag;
    logic               r_den_neg;
    logic signed [31:0] r_recip;

    logic signed [31:0] n_elem;
    logic signed [63:0] n_prod;
    logic signed [49:0] n_term;
    logic signed [49:0] n_rowsum;
    logic signed [31:0] n_rowsat;
    logic               n_rowflag;
    logic [33:0]        n_trial;
    logic signed [31:0] n_num;
    logic signed [63:0] n_sprod;
    logic signed [31:0] n_ssat;
    logic               n_sflag;
    logic signed [31:0] n_den;
    logic signed [31:0] n_recip;
    logic               n_recip_sat;

    assign n_elem = r_mat[{i_cmd.col, i_cmd.row}];
    assign n_prod = 64'(n_elem) * 64'(r_vec[i_cmd.col]);
    // floor shift by arithmetic shift
    assign n_term = 50'(r_prod >>> 16);
    // last product of the row still sits in r_prod
    assign n_rowsum = r_acc + n_term;
    assign n_den = r_res[3];

    always_comb begin
        n_rowsat = hvt_pkg::sat32(66'(n_rowsum), n_rowflag);
        n_trial = {r_rem, 1'b0} - {2'b00, r_mag};
        n_num = r_res[i_cmd.scale_idx];
        n_sprod = 64'(n_num) * 64'(r_recip);
        n_ssat = hvt_pkg::sat32(66'(r_prod >>> 16), n_sflag);
        if (!r_den_neg) begin
            n_recip_sat = (r_quo > 33'h0_7FFF_FFFF);
            n_recip = n_recip_sat ? hvt_pkg::S32_MAX : $signed(r_quo[31:0]);
        end else begin
            n_recip_sat = (r_quo > 33'h0_8000_0000);
            n_recip = n_recip_sat ? hvt_pkg::S32_MIN : $signed(32'(-r_quo));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_mat[i] <= (i % 5 == 0) ? hvt_pkg::Q_ONE : 32'sd0;
            end
            r_div_busy <= 1'b0;
            r_div_done <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            o_valid <= i_cmd.out_fire;
            if (i_cmd.mat_wr) begin
                r_mat[i_elem_index] <= i_elem_value;
            end
            r_div_done <= r_div_busy && !i_cmd.div_start && (r_div_cnt == 6'd33);
            if (i_cmd.div_start) begin
                r_div_busy <= 1'b1;
            end else if (r_div_cnt == 6'd33 || n_den == 32'sd0) begin
                // drop the divide on a zero denominator
                r_div_busy <= 1'b0;
            end
        end
    end

    // multiply-accumulate and result path; payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_vec) begin
            r_vec[0] <= i_in_x;
            r_vec[1] <= i_in_y;
            r_vec[2] <= i_in_z;
            r_vec[3] <= (i_func == hvt_pkg::FUNC_POINT) ? hvt_pkg::Q_ONE : i_in_w;
            r_point  <= (i_func == hvt_pkg::FUNC_POINT);
            r_sat    <= 1'b0;
        end
        // the product register holds the MAC command's product in the cycle after it
        r_prod <= i_cmd.scale ? n_sprod : n_prod;
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.mac && i_cmd.col != 2'd0) begin
            r_acc <= n_rowsum;
        end
        if (i_cmd.row_store) begin
            r_res[i_cmd.row] <= n_rowsat;
            r_sat <= r_sat | n_rowflag;
        end
        if (i_cmd.div_start) begin
            r_div_cnt <= 6'd0;
            r_rem     <= '0;
            r_quo     <= '0;
            r_sat_num <= r_sat | n_rowflag;
        end else if (r_div_busy && r_div_cnt == 6'd0) begin
            r_mag     <= n_den[31] ? 32'(-33'(n_den)) : n_den;
            r_den_neg <= n_den[31];
            r_rem     <= 33'd1;   // dividend 2^32: leading one, then 32 zero bits
            r_div_cnt <= 6'd1;
        end else if (r_div_busy && r_div_cnt != 6'd33) begin
            if (!n_trial[33]) begin
                r_rem <= n_trial[32:0];
                r_quo <= {r_quo[31:0], 1'b1};
            end else begin
                r_rem <= {r_rem[31:0], 1'b0};
                r_quo <= {r_quo[31:0], 1'b0};
            end
            r_div_cnt <= r_div_cnt + 6'd1;
        end
        if (r_div_done) begin
            r_recip <= n_recip;
            r_sat   <= r_sat_num | n_recip_sat;
        end
        if (i_cmd.scale_store) begin
            r_res[i_cmd.scale_idx] <= n_ssat;
            r_sat <= r_sat | n_sflag;
        end
        if (i_cmd.out_fire) begin
            if (r_point && o_status.den_zero) begin
                o_out_x <= '0;
                o_out_y <= '0;
                o_out_z <= '0;
                o_div_by_zero <= 1'b1;
                o_saturated <= 1'b0;
            end else begin
                o_out_x <= r_res[0];
                o_out_y <= r_res[1];
                o_out_z <= r_res[2];
                o_div_by_zero <= 1'b0;
                o_saturated <= r_sat;
            end
            o_out_w <= r_point ? 32'sd0 : r_res[3];
        end
    end

    assign o_status.den_zero = (n_den == 32'sd0);
    assign o_status.div_done = r_div_done;

endmodule

>>> tb/homogeneous_vertex_transform_core_tb.sv
module homogeneous_vertex_transform_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_RANDOM       = 1000;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    typedef struct {
        logic [1:0]         func;
        logic [3:0]         idx;
        logic signed [31:0] value;
        logic signed [31:0] x, y, z, w;
    } t_word;

    typedef struct {
        logic signed [31:0] x, y, z, w;
        logic               dz;
        logic               sat;
    } t_vertex;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_func;
    logic [3:0]         i_elem_index;
    logic signed [31:0] i_elem_value;
    logic signed [31:0] i_in_x, i_in_y, i_in_z, i_in_w;
    logic               o_valid;
    logic signed [31:0] o_out_x, o_out_y, o_out_z, o_out_w;
    logic               o_div_by_zero;
    logic               o_saturated;

    t_word   pending_words[$];
    t_vertex expected_vertices[$];
    logic signed [31:0] model_matrix[16];
    int  n_errors;
    int  n_results;
    int  n_points;
    int  n_zero_den;
    int  idle_cycles;
    int  burst_left;
    int  gap_left;
    bit  word_issued;

    homogeneous_vertex_transform_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_elem_index  (i_elem_index),
        .i_elem_value  (i_elem_value),
        .i_in_x        (i_in_x),
        .i_in_y        (i_in_y),
        .i_in_z        (i_in_z),
        .i_in_w        (i_in_w),
        .o_valid       (o_valid),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_z       (o_out_z),
        .o_out_w       (o_out_w),
        .o_div_by_zero (o_div_by_zero),
        .o_saturated   (o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v,
                                                   inout bit flag);
        if (v > 64'sh7FFF_FFFF) begin
            flag = 1'b1;
            return 64'sh7FFF_FFFF;
        end
        if (v < -64'sh8000_0000) begin
            flag = 1'b1;
            return -64'sh8000_0000;
        end
        return v;
    endfunction

    // arithmetic shift is a floor shift for signed operands
    function automatic logic signed [63:0] dot_row(input int row,
                                                   input logic signed [63:0] vec[4],
                                                   inout bit flag);
        logic signed [63:0] acc;
        logic signed [63:0] prod;
        acc = 0;
        for (int c = 0; c < 4; c++) begin
            prod = 64'(model_matrix[c * 4 + row]) * vec[c];
            acc += prod >>> 16;
        end
        return clamp32(acc, flag);
    endfunction

    function automatic void transform_word(input t_word wd);
        logic signed [63:0] vec[4];
        logic signed [63:0] num[3];
        logic signed [63:0] den;
        logic signed [63:0] recip;
        logic [63:0]        mag;
        logic [63:0]        quo;
        bit                 flag;
        bit                 row_flag;
        t_vertex            vx;
        flag = 1'b0;
        row_flag = 1'b0;
        vx = '{default: 0};
        case (wd.func)
            hvt_pkg::FUNC_WRITE: model_matrix[wd.idx] = wd.value;
            hvt_pkg::FUNC_VEC: begin
                vec = '{64'(wd.x), 64'(wd.y), 64'(wd.z), 64'(wd.w)};
                vx.x = 32'(dot_row(0, vec, flag));
                vx.y = 32'(dot_row(1, vec, flag));
                vx.z = 32'(dot_row(2, vec, flag));
                vx.w = 32'(dot_row(3, vec, flag));
                vx.sat = flag;
                expected_vertices.push_back(vx);
            end
            hvt_pkg::FUNC_POINT: begin
                vec = '{64'(wd.x), 64'(wd.y), 64'(wd.z), 64'(hvt_pkg::Q_ONE)};
                den = dot_row(3, vec, row_flag);
                for (int r = 0; r < 3; r++) num[r] = dot_row(r, vec, row_flag);
                if (den == 0) begin
                    vx.dz = 1'b1;
                end else begin
                    flag = row_flag;
                    mag = (den < 0) ? 64'(-den) : 64'(den);
                    quo = (64'd1 << 32) / mag;
                    if (den > 0) begin
                        if (quo > 64'h7FFF_FFFF) begin
                            flag = 1'b1;
                            quo = 64'h7FFF_FFFF;
                        end
                        recip = $signed(quo);
                    end else begin
                        if (quo > 64'h8000_0000) begin
                            flag = 1'b1;
                            quo = 64'h8000_0000;
                        end
                        recip = -$signed(quo);
                    end
                    vx.x = 32'(clamp32((num[0] * recip) >>> 16, flag));
                    vx.y = 32'(clamp32((num[1] * recip) >>> 16, flag));
                    vx.z = 32'(clamp32((num[2] * recip) >>> 16, flag));
                    vx.sat = flag;
                end
                expected_vertices.push_back(vx);
            end
            default: ;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_q(input int mode);
        case (mode)
            0: return $signed($urandom());
            1: return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
            2: return $signed($urandom_range(32'h0100_0000)) - 32'sh0080_0000;
            default: return $signed($urandom_range(32'h0000_0400)) - 32'sh0000_0200;
        endcase
    endfunction

    task automatic queue_word(input logic [1:0] func, input logic [3:0] idx,
                              input logic signed [31:0] value,
                              input logic signed [31:0] x, input logic signed [31:0] y,
                              input logic signed [31:0] z, input logic signed [31:0] w);
        t_word wd;
        wd = '{func, idx, value, x, y, z, w};
        pending_words.push_back(wd);
    endtask

    task automatic queue_identity();
        for (int i = 0; i < 16; i++)
            queue_word(hvt_pkg::FUNC_WRITE, 4'(i),
                       (i % 5 == 0) ? hvt_pkg::Q_ONE : 32'sd0,
                       32'sd0, 32'sd0, 32'sd0, 32'sd0);
    endtask

    // driver: bursts of words with random gaps
    always @(negedge i_clk) begin
        t_word wd;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && word_issued) begin
            start <= 1'b0;
        end else if (!start) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (pending_words.size() > 0) begin
                wd = pending_words.pop_front();
                transform_word(wd);
                start        <= 1'b1;
                i_func       <= wd.func;
                i_elem_index <= wd.idx;
                i_elem_value <= wd.value;
                i_in_x       <= wd.x;
                i_in_y       <= wd.y;
                i_in_z       <= wd.z;
                i_in_w       <= wd.w;
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(8);
                    gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
                end
            end
        end
    end

    // acceptance marker sampled on the rising edge
    always @(posedge i_clk) begin
        word_issued <= i_rst_n && start && !busy;
        if (i_rst_n && start && !busy) begin
            idle_cycles <= 0;
        end else if (i_rst_n && o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_vertex ex;
        if (i_rst_n && o_valid) begin
            n_results++;
            if (expected_vertices.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result x=%h y=%h z=%h w=%h", $time,
                         o_out_x, o_out_y, o_out_z, o_out_w);
            end else begin
                ex = expected_vertices.pop_front();
                if (ex.dz) n_zero_den++;
                if (o_out_x !== ex.x || o_out_y !== ex.y || o_out_z !== ex.z ||
                    o_out_w !== ex.w || o_div_by_zero !== ex.dz ||
                    o_saturated !== ex.sat) begin
                    n_errors++;
                    $display("%0t: expected x=%h y=%h z=%h w=%h dz=%b sat=%b", $time,
                             ex.x, ex.y, ex.z, ex.w, ex.dz, ex.sat);
                    $display("%0t: actual   x=%h y=%h z=%h w=%h dz=%b sat=%b", $time,
                             o_out_x, o_out_y, o_out_z, o_out_w,
                             o_div_by_zero, o_saturated);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d words and %0d results outstanding",
                     $time, pending_words.size(), expected_vertices.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int op;
        int mode;
        int vec_mode;
        start        = 1'b0;
        word_issued  = 1'b0;
        i_rst_n      = 1'b0;
        i_func       = hvt_pkg::FUNC_WRITE;
        i_elem_index = '0;
        i_elem_value = '0;
        i_in_x       = '0;
        i_in_y       = '0;
        i_in_z       = '0;
        i_in_w       = '0;
        n_errors     = 0;
        n_results    = 0;
        n_points     = 0;
        n_zero_den   = 0;
        idle_cycles  = 0;
        burst_left   = 0;
        gap_left     = 0;
        for (int i = 0; i < 16; i++)
            model_matrix[i] = (i % 5 == 0) ? hvt_pkg::Q_ONE : 32'sd0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: identity with extremes, unused selector, zero and tiny denominators
        queue_word(hvt_pkg::FUNC_VEC, 4'd0, 32'sd0, hvt_pkg::S32_MAX, hvt_pkg::S32_MIN,
                   hvt_pkg::Q_ONE, -32'sd1);
        queue_word(hvt_pkg::FUNC_POINT, 4'd0, 32'sd0, hvt_pkg::S32_MIN, hvt_pkg::S32_MAX,
                   32'sd3, 32'sd0);
        queue_word(FUNC_NONE, 4'hF, hvt_pkg::S32_MIN, hvt_pkg::S32_MAX, hvt_pkg::S32_MAX,
                   hvt_pkg::S32_MAX, hvt_pkg::S32_MAX);
        queue_word(hvt_pkg::FUNC_WRITE, 4'd15, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
        queue_word(hvt_pkg::FUNC_POINT, 4'd0, 32'sd0, hvt_pkg::Q_ONE, hvt_pkg::Q_ONE,
                   hvt_pkg::Q_ONE, 32'sd0);
        queue_word(hvt_pkg::FUNC_WRITE, 4'd15, 32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
        queue_word(hvt_pkg::FUNC_POINT, 4'd0, 32'sd0, hvt_pkg::S32_MAX, -32'sd5,
                   hvt_pkg::Q_ONE, 32'sd0);
        queue_word(hvt_pkg::FUNC_WRITE, 4'd15, -32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
        queue_word(hvt_pkg::FUNC_POINT, 4'd0, 32'sd0, hvt_pkg::S32_MIN, 32'sd7,
                   -hvt_pkg::Q_ONE, 32'sd0);
        queue_word(hvt_pkg::FUNC_WRITE, 4'd15, hvt_pkg::S32_MIN, 32'sd0, 32'sd0, 32'sd0,
                   32'sd0);
        queue_word(hvt_pkg::FUNC_POINT, 4'd0, 32'sd0, hvt_pkg::Q_ONE, -hvt_pkg::Q_ONE,
                   hvt_pkg::S32_MAX, 32'sd0);
        queue_word(hvt_pkg::FUNC_WRITE, 4'd0, hvt_pkg::S32_MAX, 32'sd0, 32'sd0, 32'sd0,
                   32'sd0);
        queue_word(hvt_pkg::FUNC_WRITE, 4'd5, hvt_pkg::S32_MIN, 32'sd0, 32'sd0, 32'sd0,
                   32'sd0);
        queue_word(hvt_pkg::FUNC_VEC, 4'd0, 32'sd0, hvt_pkg::S32_MAX, hvt_pkg::S32_MAX,
                   hvt_pkg::S32_MIN, hvt_pkg::S32_MIN);
        queue_word(hvt_pkg::FUNC_VEC, 4'd0, 32'sd0, hvt_pkg::S32_MIN, hvt_pkg::S32_MIN,
                   hvt_pkg::S32_MAX, hvt_pkg::S32_MAX);
        queue_identity();

        // random: mostly modest matrices so the divide path is exercised sensibly
        for (int n = 0; n < N_RANDOM; n++) begin
            op = $urandom_range(99);
            mode = $urandom_range(3);
            vec_mode = $urandom_range(3);
            if (op < 30)
                queue_word(hvt_pkg::FUNC_WRITE, 4'($urandom()), rand_q(mode), rand_q(0),
                           rand_q(0), rand_q(0), rand_q(0));
            else if (op < 60)
                queue_word(hvt_pkg::FUNC_VEC, 4'($urandom()), rand_q(0), rand_q(vec_mode),
                           rand_q(vec_mode), rand_q(vec_mode), rand_q(vec_mode));
            else if (op < 95)
                queue_word(hvt_pkg::FUNC_POINT, 4'($urandom()), rand_q(0),
                           rand_q(vec_mode), rand_q(vec_mode), rand_q(vec_mode),
                           rand_q(0));
            else if (op < 98)
                queue_word(FUNC_NONE, 4'($urandom()), rand_q(0), rand_q(0), rand_q(0),
                           rand_q(0), rand_q(0));
            else
                queue_identity();
            if (op >= 60 && op < 95) n_points++;
        end

        wait (pending_words.size() == 0 && !start);
        wait (expected_vertices.size() == 0);
        repeat (100) @(posedge i_clk);

        $display("Run covered %0d results, %0d random point transforms, %0d zero denominators.",
                 n_results, n_points, n_zero_den);
        if (n_errors == 0 && expected_vertices.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
